@@ hw/rtl/sfp_pkg.sv @@
package sfp_pkg;

  localparam int unsigned NumReadings = 4;
  localparam int unsigned PosW        = 5;
  localparam int unsigned CapIdxW     = 6;
  localparam int unsigned ReadingW    = 16;
  localparam int unsigned CfgIdxW     = 3;
  localparam int unsigned CfgDataW    = 8;

  typedef logic [CapIdxW-1:0] cap_idx_t;
  typedef logic [NumReadings-1:0][PosW-1:0] pos_arr_t;
  typedef logic [NumReadings-1:0][ReadingW-1:0] reading_arr_t;

  typedef enum logic [2:0] {
    PhHead1 = 3'd0,
    PhHead2 = 3'd1,
    PhData  = 3'd2,
    PhCsHi  = 3'd3,
    PhCsLo  = 3'd4
  } phase_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgHeaderFirst  = 3'd0,
    CfgHeaderSecond = 3'd1,
    CfgPm1Pos       = 3'd2,
    CfgPm25Pos      = 3'd3,
    CfgPm4Pos       = 3'd4,
    CfgPm10Pos      = 3'd5
  } cfg_idx_e;

  localparam logic [7:0]      HeaderFirstRst  = 8'd66;
  localparam logic [7:0]      HeaderSecondRst = 8'd77;
  localparam logic [PosW-1:0] Pm1PosRst       = 5'd4;
  localparam logic [PosW-1:0] Pm25PosRst      = 5'd6;
  localparam logic [PosW-1:0] Pm4PosRst       = 5'd8;
  localparam logic [PosW-1:0] Pm10PosRst      = 5'd10;

endpackage

@@ hw/rtl/sensor_frame_parser_sum_check_top.sv @@
// Serial frame parser with a 16-bit sum check. Bytes enter one per transfer on the slave
// stream; the block hunts for the two configured header bytes, collects a frame of
// FRAME_LEN bytes and, on the last checksum byte, presents one result on the master stream
// carrying the four big-endian readings taken at the configured byte positions and a pass
// flag in tuser. A failing frame is still delivered, with the flag low. A byte can be
// accepted each cycle: the parser state is updated from the accepted byte and the result
// sits in an output register, so input stalls only when a finished result is still waiting
// and the byte would complete another frame. Configuration writes are always accepted and
// act from the next byte.
module sensor_frame_parser_sum_check_top #(
  parameter int unsigned FRAME_LEN = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // rx_byte [7:0]
  input  logic [7:0]  s_axis_tdata_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // reading_pm1 [15:0], reading_pm25 [31:16], reading_pm4 [47:32], reading_pm10 [63:48]
  output logic [63:0] m_axis_tdata_o,
  // frame_ok [0]
  output logic [0:0]  m_axis_tuser_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [sfp_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [sfp_pkg::CfgDataW-1:0] cfg_data_i
);

  localparam int unsigned IdxW = $clog2(FRAME_LEN);

  logic [7:0]            hdr_first_q, hdr_second_q;
  sfp_pkg::pos_arr_t     pos_q;

  sfp_pkg::phase_e       phase_q, phase_d;
  logic [IdxW-1:0]       byte_idx_q, byte_idx_d, idx_inc;
  logic [15:0]           sum_q, sum_d;
  logic [7:0]            cs_hi_q, cs_hi_d;
  sfp_pkg::reading_arr_t held_q, held_d;

  logic                  out_valid_q, out_valid_d;
  logic                  out_load;
  logic                  out_ok_q, out_ok_d;
  sfp_pkg::reading_arr_t out_rd_q;

  sfp_pkg::reading_arr_t cap_base, cap_a_res, cap_b_res;
  sfp_pkg::cap_idx_t     cap_a_idx;
  logic [7:0]            cap_a_byte;
  logic                  cap_b_en;
  logic                  accept;
  logic [7:0]            rx;

  assign rx     = s_axis_tdata_i;
  assign accept = s_axis_tvalid_i && s_axis_tready_o;
  assign s_axis_tready_o = !(phase_q == sfp_pkg::PhCsLo && out_valid_q && !m_axis_tready_i);
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_first_q  <= sfp_pkg::HeaderFirstRst;
      hdr_second_q <= sfp_pkg::HeaderSecondRst;
      pos_q[0]     <= sfp_pkg::Pm1PosRst;
      pos_q[1]     <= sfp_pkg::Pm25PosRst;
      pos_q[2]     <= sfp_pkg::Pm4PosRst;
      pos_q[3]     <= sfp_pkg::Pm10PosRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        sfp_pkg::CfgHeaderFirst:  hdr_first_q  <= cfg_data_i;
        sfp_pkg::CfgHeaderSecond: hdr_second_q <= cfg_data_i;
        sfp_pkg::CfgPm1Pos:       pos_q[0]     <= cfg_data_i[sfp_pkg::PosW-1:0];
        sfp_pkg::CfgPm25Pos:      pos_q[1]     <= cfg_data_i[sfp_pkg::PosW-1:0];
        sfp_pkg::CfgPm4Pos:       pos_q[2]     <= cfg_data_i[sfp_pkg::PosW-1:0];
        sfp_pkg::CfgPm10Pos:      pos_q[3]     <= cfg_data_i[sfp_pkg::PosW-1:0];
        default: ;
      endcase
    end
  end

  // A completed header clears the readings and captures both header bytes.
  always_comb begin
    if (phase_q == sfp_pkg::PhHead2) begin
      cap_base   = '0;
      cap_a_idx  = '0;
      cap_a_byte = hdr_first_q;
      cap_b_en   = 1'b1;
    end else begin
      cap_base   = held_q;
      cap_a_idx  = sfp_pkg::cap_idx_t'(byte_idx_q);
      cap_a_byte = rx;
      cap_b_en   = 1'b0;
    end
  end

  sfp_capture u_cap_a (
    .base_i   (cap_base),
    .pos_i    (pos_q),
    .idx_i    (cap_a_idx),
    .byte_i   (cap_a_byte),
    .en_i     (1'b1),
    .result_o (cap_a_res)
  );

  sfp_capture u_cap_b (
    .base_i   (cap_a_res),
    .pos_i    (pos_q),
    .idx_i    (sfp_pkg::cap_idx_t'(1)),
    .byte_i   (rx),
    .en_i     (cap_b_en),
    .result_o (cap_b_res)
  );

  assign idx_inc = byte_idx_q + IdxW'(1);

  always_comb begin
    phase_d    = phase_q;
    byte_idx_d = byte_idx_q;
    sum_d      = sum_q;
    cs_hi_d    = cs_hi_q;
    held_d     = held_q;
    out_load   = 1'b0;
    out_ok_d   = 1'b0;
    if (accept) begin
      unique case (phase_q)
        sfp_pkg::PhHead2: begin
          priority if (rx == hdr_first_q) begin
            phase_d = sfp_pkg::PhHead2;
          end else if (rx != hdr_second_q) begin
            phase_d = sfp_pkg::PhHead1;
          end else begin
            held_d     = cap_b_res;
            sum_d      = {8'h00, hdr_first_q} + {8'h00, rx};
            byte_idx_d = IdxW'(2);
            phase_d    = sfp_pkg::PhData;
          end
        end
        sfp_pkg::PhData: begin
          held_d     = cap_b_res;
          sum_d      = sum_q + {8'h00, rx};
          byte_idx_d = idx_inc;
          if (idx_inc >= IdxW'(FRAME_LEN - 2)) begin
            phase_d = sfp_pkg::PhCsHi;
          end
        end
        sfp_pkg::PhCsHi: begin
          held_d     = cap_b_res;
          cs_hi_d    = rx;
          byte_idx_d = idx_inc;
          phase_d    = sfp_pkg::PhCsLo;
        end
        sfp_pkg::PhCsLo: begin
          held_d     = cap_b_res;
          out_load   = 1'b1;
          out_ok_d   = (sum_q == {cs_hi_q, rx});
          byte_idx_d = '0;
          phase_d    = sfp_pkg::PhHead1;
        end
        default: begin
          phase_d = (rx == hdr_first_q) ? sfp_pkg::PhHead2 : sfp_pkg::PhHead1;
        end
      endcase
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= sfp_pkg::PhHead1;
      byte_idx_q  <= '0;
      sum_q       <= '0;
      cs_hi_q     <= '0;
      held_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      byte_idx_q  <= byte_idx_d;
      sum_q       <= sum_d;
      cs_hi_q     <= cs_hi_d;
      held_q      <= held_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_ok_q <= out_ok_d;
      out_rd_q <= cap_b_res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_rd_q;
  assign m_axis_tuser_o  = out_ok_q;

endmodule

@@ hw/rtl/sfp_capture.sv @@
module sfp_capture (
  input  sfp_pkg::reading_arr_t base_i,
  input  sfp_pkg::pos_arr_t     pos_i,
  input  sfp_pkg::cap_idx_t     idx_i,
  input  logic [7:0]            byte_i,
  input  logic                  en_i,
  output sfp_pkg::reading_arr_t result_o
);

  always_comb begin
    sfp_pkg::cap_idx_t p_hi;
    sfp_pkg::cap_idx_t p_lo;
    result_o = base_i;
    for (int k = 0; k < sfp_pkg::NumReadings; k++) begin
      p_hi = sfp_pkg::cap_idx_t'(pos_i[k]);
      p_lo = p_hi + sfp_pkg::cap_idx_t'(1);
      if (en_i) begin
        if (idx_i == p_hi) begin
          result_o[k][15:8] = byte_i;
        end else if (idx_i == p_lo) begin
          result_o[k][7:0] = byte_i;
        end
      end
    end
  end

endmodule
